// ===== rtl/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types, constants and a helper function of the first-fit page allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int ADDR_W    = 64;
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;

  typedef logic [1:0] status_t;

  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_NO_FREE = 2'd1;
  localparam status_t ST_RANGE   = 2'd2;

  typedef struct packed {
    logic set;
    logic clear;
  } sum_cmd_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } find_t;

  // Lowest bit that is zero in word and one in mask.
  function automatic find_t lowest_zero(input logic [WORD_BITS-1:0] word,
                                        input logic [WORD_BITS-1:0] mask);
    find_t                r;
    logic [WORD_BITS-1:0] freeb;
    freeb   = ~word & mask;
    r.found = |freeb;
    r.pos   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (freeb[i]) begin
        r.pos = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/ffpa_if.sv =====
// ----------------------------------------------------------------------------
// ffpa_in_if / ffpa_out_if
// Valid/ready channels for requests and results of the page allocator.
// ----------------------------------------------------------------------------
interface ffpa_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] page_address;

  modport source(output valid, output kind, output page_address, input ready);
  modport sink(input valid, input kind, input page_address, output ready);
endinterface

interface ffpa_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] allocated_address;
  logic [1:0]  status;

  modport source(output valid, output allocated_address, output status, input ready);
  modport sink(input valid, input allocated_address, input status, output ready);
endinterface

// ===== rtl/ffpa_ram.sv =====
// ----------------------------------------------------------------------------
// ffpa_ram
// Simple dual-port synchronous RAM with one write and one registered read port.
// ----------------------------------------------------------------------------
module ffpa_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 64,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ffpa_summary.sv =====
// ----------------------------------------------------------------------------
// ffpa_summary
// Top-level full flags, one per summary word, with a registered first-free search.
// ----------------------------------------------------------------------------
module ffpa_summary import ffpa_pkg::*; #(
  parameter int SUM_COUNT = 4,
  parameter int SUM_W     = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sum_cmd_t         cmd,
  input  logic [SUM_W-1:0] idx,
  output logic             any_free_r,
  output logic [SUM_W-1:0] first_free_r
);

  logic [SUM_COUNT-1:0] full_r;
  logic                 any_free_nxt;
  logic [SUM_W-1:0]     first_free_nxt;

  always_comb begin
    any_free_nxt   = 1'b0;
    first_free_nxt = '0;
    for (int i = SUM_COUNT - 1; i >= 0; i--) begin
      if (!full_r[i]) begin
        any_free_nxt   = 1'b1;
        first_free_nxt = SUM_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r       <= '0;
      any_free_r   <= 1'b0;
      first_free_r <= '0;
    end else begin
      if (cmd.set) begin
        full_r[idx] <= 1'b1;
      end else if (cmd.clear) begin
        full_r[idx] <= 1'b0;
      end
      any_free_r   <= any_free_nxt;
      first_free_r <= first_free_nxt;
    end
  end

endmodule

// ===== rtl/first_fit_page_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// Bitmap page allocator: hands out the lowest free page and frees pages by address.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload                          Transfer
//  in_ch    sink       kind, page_address               valid & ready
//  out_ch   source     allocated_address, status        valid & ready
//  cfg      write      cfg_wdata -> base_address        cfg_we
//
//  An allocate that finds a page goes through the summary flags, summary word
//  read, bitmap read-modify-write and address add; a free through the bitmap
//  and summary word read and write. No free page or an out-of-range free goes
//  straight to the result. After reset both memories are cleared, one bitmap
//  word per cycle, with in_ch.ready low. One transaction is in work at a time;
//  a stalled result holds back the next result, not the next request.
// ----------------------------------------------------------------------------
module first_fit_page_allocator import ffpa_pkg::*; #(
  parameter int PAGE_COUNT     = 16384,
  parameter int PAGE_SIZE_LOG2 = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata,
  ffpa_in_if.sink           in_ch,
  ffpa_out_if.source        out_ch
);

  localparam int WORD_COUNT = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int SUM_COUNT  = (WORD_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int SUM_W      = (SUM_COUNT > 1) ? $clog2(SUM_COUNT) : 1;
  localparam int BM_TAIL    = PAGE_COUNT % WORD_BITS;
  localparam int SUM_TAIL   = WORD_COUNT % WORD_BITS;
  localparam logic [WORD_BITS-1:0] BM_LAST_MASK =
    (BM_TAIL == 0) ? {WORD_BITS{1'b1}} : ((64'd1 << BM_TAIL) - 64'd1);
  localparam logic [WORD_BITS-1:0] SUM_LAST_MASK =
    (SUM_TAIL == 0) ? {WORD_BITS{1'b1}} : ((64'd1 << SUM_TAIL) - 64'd1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SEARCH, S_L1, S_BM, S_FCHK, S_FWR, S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [WORD_W-1:0]   clr_r, clr_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [ADDR_W-1:0]   offset_r, offset_nxt;
  logic [SUM_W-1:0]    sidx_r, sidx_nxt;
  logic [BIT_W-1:0]    sbit_r, sbit_nxt;
  logic [WORD_W-1:0]   word_r, word_nxt;
  logic [BIT_W-1:0]    pbit_r, pbit_nxt;
  status_t             status_r, status_nxt;
  logic                alloc_ok_r, alloc_ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  status_t             out_status_r, out_status_nxt;

  logic                 bm_we, bm_re, l1_we, l1_re;
  logic [WORD_W-1:0]    bm_waddr, bm_raddr;
  logic [SUM_W-1:0]     l1_waddr, l1_raddr;
  logic [WORD_BITS-1:0] bm_wdata, bm_rdata, l1_wdata, l1_rdata;
  sum_cmd_t             sum_cmd;
  logic [SUM_W-1:0]     sum_idx;
  logic                 any_free;
  logic [SUM_W-1:0]     first_free;

  logic [WORD_BITS-1:0]   bm_mask, sum_mask, bm_new, l1_new;
  find_t                  l1_find, bm_find;
  logic [SUM_W+BIT_W-1:0] wjoin, wsplit;
  logic [WORD_W-1:0]      fchk_word;
  logic                   in_range;

  ffpa_ram #(.DEPTH(WORD_COUNT), .WIDTH(WORD_BITS), .AW(WORD_W)) u_bitmap (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .re(bm_re), .raddr(bm_raddr), .rdata_r(bm_rdata)
  );

  ffpa_ram #(.DEPTH(SUM_COUNT), .WIDTH(WORD_BITS), .AW(SUM_W)) u_l1 (
    .clk(clk), .we(l1_we), .waddr(l1_waddr), .wdata(l1_wdata),
    .re(l1_re), .raddr(l1_raddr), .rdata_r(l1_rdata)
  );

  ffpa_summary #(.SUM_COUNT(SUM_COUNT), .SUM_W(SUM_W)) u_summary (
    .clk(clk), .rst_n(rst_n), .cmd(sum_cmd), .idx(sum_idx),
    .any_free_r(any_free), .first_free_r(first_free)
  );

  assign in_ch.ready              = (state_r == S_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.allocated_address = out_addr_r;
  assign out_ch.status            = out_status_r;

  always_comb begin
    bm_mask   = (word_r == WORD_W'(WORD_COUNT - 1)) ? BM_LAST_MASK : {WORD_BITS{1'b1}};
    sum_mask  = (sidx_r == SUM_W'(SUM_COUNT - 1)) ? SUM_LAST_MASK : {WORD_BITS{1'b1}};
    l1_find   = lowest_zero(l1_rdata, sum_mask);
    bm_find   = lowest_zero(bm_rdata, bm_mask);
    bm_new    = bm_rdata | (64'd1 << bm_find.pos);
    l1_new    = l1_rdata | (64'd1 << sbit_r);
    wjoin     = {sidx_r, l1_find.pos};
    fchk_word = offset_r[PAGE_SIZE_LOG2 + BIT_W +: WORD_W];
    wsplit    = (SUM_W + BIT_W)'(fchk_word);
    in_range  = (offset_r >> PAGE_SIZE_LOG2) < 64'(PAGE_COUNT);
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    base_nxt       = base_r;
    offset_nxt     = offset_r;
    sidx_nxt       = sidx_r;
    sbit_nxt       = sbit_r;
    word_nxt       = word_r;
    pbit_nxt       = pbit_r;
    status_nxt     = status_r;
    alloc_ok_nxt   = alloc_ok_r;
    out_valid_nxt  = out_valid_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    bm_we          = 1'b0;
    bm_waddr       = word_r;
    bm_wdata       = '0;
    bm_re          = 1'b0;
    bm_raddr       = word_r;
    l1_we          = 1'b0;
    l1_waddr       = sidx_r;
    l1_wdata       = '0;
    l1_re          = 1'b0;
    l1_raddr       = sidx_r;
    sum_cmd        = '0;
    sum_idx        = sidx_r;

    if (cfg_we) begin
      base_nxt = cfg_wdata;
    end
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_r;
        if (clr_r < WORD_W'(SUM_COUNT)) begin
          l1_we    = 1'b1;
          l1_waddr = clr_r[SUM_W-1:0];
        end
        if (clr_r == WORD_W'(WORD_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + WORD_W'(1);
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.kind) begin
            offset_nxt = in_ch.page_address - base_r;
            state_nxt  = S_FCHK;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        alloc_ok_nxt = 1'b0;
        if (!any_free) begin
          status_nxt = ST_NO_FREE;
          state_nxt  = S_DONE;
        end else begin
          l1_re     = 1'b1;
          l1_raddr  = first_free;
          sidx_nxt  = first_free;
          state_nxt = S_L1;
        end
      end
      S_L1: begin
        sbit_nxt  = l1_find.pos;
        word_nxt  = wjoin[WORD_W-1:0];
        bm_re     = 1'b1;
        bm_raddr  = wjoin[WORD_W-1:0];
        state_nxt = S_BM;
      end
      S_BM: begin
        pbit_nxt     = bm_find.pos;
        bm_we        = 1'b1;
        bm_wdata     = bm_new;
        if (&(bm_new | ~bm_mask)) begin
          l1_we    = 1'b1;
          l1_wdata = l1_new;
          if (&(l1_new | ~sum_mask)) begin
            sum_cmd.set = 1'b1;
          end
        end
        status_nxt   = ST_DONE;
        alloc_ok_nxt = 1'b1;
        state_nxt    = S_DONE;
      end
      S_FCHK: begin
        alloc_ok_nxt = 1'b0;
        if (!in_range) begin
          status_nxt = ST_RANGE;
          state_nxt  = S_DONE;
        end else begin
          word_nxt  = fchk_word;
          pbit_nxt  = offset_r[PAGE_SIZE_LOG2 +: BIT_W];
          sidx_nxt  = wsplit[SUM_W+BIT_W-1:BIT_W];
          sbit_nxt  = wsplit[BIT_W-1:0];
          bm_re     = 1'b1;
          bm_raddr  = fchk_word;
          l1_re     = 1'b1;
          l1_raddr  = wsplit[SUM_W+BIT_W-1:BIT_W];
          state_nxt = S_FWR;
        end
      end
      S_FWR: begin
        bm_we         = 1'b1;
        bm_wdata      = bm_rdata & ~(64'd1 << pbit_r);
        l1_we         = 1'b1;
        l1_wdata      = l1_rdata & ~(64'd1 << sbit_r);
        sum_cmd.clear = 1'b1;
        status_nxt    = ST_DONE;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = alloc_ok_r ?
                           base_r + (64'({word_r, pbit_r}) << PAGE_SIZE_LOG2) : '0;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
    offset_r     <= offset_nxt;
    sidx_r       <= sidx_nxt;
    sbit_r       <= sbit_nxt;
    word_r       <= word_nxt;
    pbit_r       <= pbit_nxt;
    status_r     <= status_nxt;
    alloc_ok_r   <= alloc_ok_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

// ===== rtl/ffpa_checker.sv =====
// ----------------------------------------------------------------------------
// ffpa_checker
// Port-level checks of the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffpa_checker import ffpa_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] out_addr,
  input logic [1:0]        out_status
);

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_NO_FREE ||
                   out_status == ST_RANGE))
    else $error("result status is not a defined code");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_DONE) |-> (out_addr == '0))
    else $error("failed transaction carries a nonzero address");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another transaction is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_addr) && $stable(out_status)))
    else $error("stalled result changed or dropped");

endmodule

bind first_fit_page_allocator ffpa_checker u_ffpa_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_addr(out_ch.allocated_address),
  .out_status(out_ch.status)
);
